/* hw/rtl/hpse_pkg.sv */
// shared constants and types for the hall period speed estimator
package hpse_pkg;

  localparam int AGE_W    = 16;
  localparam int PERIOD_W = 16;
  localparam int SPEED_W  = 17;
  localparam int DATA_W   = 32;
  localparam int PADDR_W  = 3;

  localparam logic [SPEED_W-1:0] SPEED_MAX     = {SPEED_W{1'b1}};
  localparam logic [AGE_W-1:0]   TIMEOUT_RESET = 16'd800;
  localparam logic [AGE_W-1:0]   AGE_RESET     = 16'hFFFF;

  // register word index, taken from paddr above the byte offset
  localparam logic REG_TIMEOUT = 1'b0;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

/* hw/rtl/hpse_divider.sv */
// bit-serial restoring divider with saturation of the quotient to the speed width
module hpse_divider import hpse_pkg::*; #(
  parameter int NUM_W = 24,
  parameter int DEN_W = 23
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [NUM_W-1:0]   num,
  input  logic [DEN_W-1:0]   den,
  output div_status_t        status,
  output logic [SPEED_W-1:0] quot
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] q_r;
  logic [DEN_W-1:0] rem_r;
  logic [DEN_W-1:0] den_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;

  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             ge;
  logic [DEN_W-1:0] rem_nxt;
  logic             sat;

  // shift in the next numerator bit, subtract when it fits
  assign trial   = {rem_r, q_r[NUM_W-1]};
  assign diff    = trial - {1'b0, den_r};
  assign ge      = trial >= {1'b0, den_r};
  assign rem_nxt = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(NUM_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= num;
      den_r <= den;
      rem_r <= '0;
    end else if (busy_r) begin
      q_r   <= {q_r[NUM_W-2:0], ge};
      rem_r <= rem_nxt;
    end
  end

  assign sat         = |q_r[NUM_W-1:SPEED_W];
  assign quot        = sat ? SPEED_MAX : q_r[SPEED_W-1:0];
  assign status.busy = busy_r;
  assign status.done = done_r;

endmodule

/* hw/rtl/hall_period_speed_estimator_core.sv */
// top level of the hall period speed estimator: edge tracking, period ring and output stage
//
// One beat per control tick. The block tracks the Hall edge age against timeout_ticks,
// pushes each new nonzero period into a ring of RING_DEPTH entries with a running sum,
// and reports speed = floor(TIMER_RATE_HZ * fill / (6 * sum)), saturated to 17 bits.
// A tick that pushes no period loads its result straight into the output register.
// A tick that pushes a period passes the start, divide and flush states; NUM_W, the
// bit width of TIMER_RATE_HZ * RING_DEPTH, at least 18, sizes the bit-serial divider,
// which produces one quotient bit per cycle. The input stalls while that division
// runs. A new beat is taken while the previous result waits only if that result is
// taken in the same cycle. timeout_ticks sits at byte address 0 of the register port.
module hall_period_speed_estimator_core import hpse_pkg::*; #(
  parameter int RING_DEPTH    = 12,
  parameter int TIMER_RATE_HZ = 500000
) (
  input  logic                clk,
  input  logic                rst_n,

  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_clear,
  input  logic [AGE_W-1:0]    in_edge_age,
  input  logic [PERIOD_W-1:0] in_period_ticks,

  output logic                out_valid,
  input  logic                out_stall,
  output logic [SPEED_W-1:0]  out_speed_erps,
  output logic                out_signal_valid,

  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [DATA_W-1:0]   pwdata,
  output logic [DATA_W-1:0]   prdata,
  output logic                pready
);

  localparam int SUM_W     = $clog2(RING_DEPTH * 65535 + 1);
  localparam int DEN_W     = SUM_W + 3;
  localparam int FILL_W    = $clog2(RING_DEPTH + 1);
  localparam int SLOT_W    = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int NUM_RAW_W = $clog2(TIMER_RATE_HZ * RING_DEPTH + 1);
  localparam int NUM_W     = (NUM_RAW_W > SPEED_W + 1) ? NUM_RAW_W : SPEED_W + 1;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_START = 2'd1;
  localparam logic [1:0] ST_DIV   = 2'd2;
  localparam logic [1:0] ST_FLUSH = 2'd3;

  logic [1:0]          state_r, state_nxt;
  logic [AGE_W-1:0]    timeout_r;
  logic [PERIOD_W-1:0] ring_r [RING_DEPTH];
  logic [SUM_W-1:0]    sum_r, sum_nxt;
  logic [SLOT_W-1:0]   slot_r, slot_nxt;
  logic [FILL_W-1:0]   fill_r, fill_nxt;
  logic                skip_r, skip_nxt;
  logic                latched_r, latched_nxt;
  logic [AGE_W-1:0]    prev_r, prev_nxt;
  logic [SPEED_W-1:0]  speed_r, speed_nxt;

  logic                out_valid_r;
  logic [SPEED_W-1:0]  out_speed_r;
  logic                out_sig_r;

  logic                accept;
  logic                out_free;
  logic                tick_valid;
  logic                edge_seen;
  logic                push;
  logic                ring_full;
  logic                out_load;
  logic [SPEED_W-1:0]  out_speed_nxt;
  logic                out_sig_nxt;

  logic                div_start;
  logic [NUM_W-1:0]    div_num;
  logic [DEN_W-1:0]    div_den;
  div_status_t         div_status;
  logic [SPEED_W-1:0]  div_quot;

  logic                cfg_write;

  assign out_free   = !out_valid_r || !out_stall;
  assign in_stall   = (state_r != ST_IDLE) || !out_free;
  assign accept     = in_valid && !in_stall;
  assign tick_valid = in_edge_age <= timeout_r;
  assign edge_seen  = tick_valid && (in_edge_age < prev_r);
  assign ring_full  = fill_r == FILL_W'(RING_DEPTH);

  always_comb begin
    state_nxt     = state_r;
    sum_nxt       = sum_r;
    slot_nxt      = slot_r;
    fill_nxt      = fill_r;
    skip_nxt      = skip_r;
    latched_nxt   = latched_r;
    prev_nxt      = prev_r;
    speed_nxt     = speed_r;
    push          = 1'b0;
    out_load      = 1'b0;
    out_speed_nxt = '0;
    out_sig_nxt   = 1'b0;
    div_start     = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_clear) begin
            sum_nxt     = '0;
            slot_nxt    = '0;
            fill_nxt    = '0;
            skip_nxt    = 1'b1;
            latched_nxt = 1'b0;
            prev_nxt    = AGE_RESET;
            speed_nxt   = '0;
            out_load    = 1'b1;
          end else begin
            // first dead tick empties the ring and arms the edge skip
            if (!tick_valid && !latched_r) begin
              sum_nxt     = '0;
              slot_nxt    = '0;
              fill_nxt    = '0;
              skip_nxt    = 1'b1;
              latched_nxt = 1'b1;
            end
            if (edge_seen) begin
              latched_nxt = 1'b0;
              if (skip_r) begin
                skip_nxt = 1'b0;
              end else if (in_period_ticks != '0) begin
                push = 1'b1;
              end
            end
            prev_nxt = in_edge_age;
            if (!tick_valid) begin
              speed_nxt = '0;
            end
            if (push) begin
              // oldest entry leaves the sum once the ring is full
              sum_nxt = sum_r - (ring_full ? SUM_W'(ring_r[slot_r]) : '0)
                        + SUM_W'(in_period_ticks);
              fill_nxt = ring_full ? fill_r : fill_r + 1'b1;
              slot_nxt = (slot_r == SLOT_W'(RING_DEPTH - 1)) ? '0 : slot_r + 1'b1;
              state_nxt = ST_START;
            end else begin
              out_load      = 1'b1;
              out_speed_nxt = speed_nxt;
              out_sig_nxt   = tick_valid;
            end
          end
        end
      end
      ST_START: begin
        div_start = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (div_status.done) begin
          speed_nxt = div_quot;
          state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          out_load      = 1'b1;
          out_speed_nxt = speed_r;
          out_sig_nxt   = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      sum_r       <= '0;
      slot_r      <= '0;
      fill_r      <= '0;
      skip_r      <= 1'b1;
      latched_r   <= 1'b0;
      prev_r      <= AGE_RESET;
      speed_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      sum_r     <= sum_nxt;
      slot_r    <= slot_nxt;
      fill_r    <= fill_nxt;
      skip_r    <= skip_nxt;
      latched_r <= latched_nxt;
      prev_r    <= prev_nxt;
      speed_r   <= speed_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_speed_r <= out_speed_nxt;
      out_sig_r   <= out_sig_nxt;
    end
    if (push) begin
      ring_r[slot_r] <= in_period_ticks;
    end
  end

  // operands for the divider, taken from the ring state left by the push
  assign div_num = NUM_W'(TIMER_RATE_HZ) * NUM_W'(fill_r);
  assign div_den = DEN_W'({sum_r, 2'b00}) + DEN_W'({sum_r, 1'b0});

  hpse_divider #(
    .NUM_W(NUM_W),
    .DEN_W(DEN_W)
  ) u_divider (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (div_start),
    .num    (div_num),
    .den    (div_den),
    .status (div_status),
    .quot   (div_quot)
  );

  // register port
  assign cfg_write = psel && penable && pwrite;
  assign pready    = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TIMEOUT_RESET;
    end else if (cfg_write && (paddr[2] == REG_TIMEOUT)) begin
      timeout_r <= pwdata[AGE_W-1:0];
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_TIMEOUT: prdata = DATA_W'(timeout_r);
      default:     prdata = '0;
    endcase
  end

  assign out_valid        = out_valid_r;
  assign out_speed_erps   = out_speed_r;
  assign out_signal_valid = out_sig_r;

`ifndef NO_ASSERTIONS
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(RING_DEPTH))
    else $error("ring fill count above depth");

  a_empty_sum: assert property (@(posedge clk) disable iff (!rst_n)
    (fill_r == '0) |-> (sum_r == '0 && slot_r == '0))
    else $error("empty ring with nonzero sum or slot");

  a_dead_speed: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_signal_valid) |-> (out_speed_erps == '0))
    else $error("nonzero speed on a dead hall signal");

  a_div_running: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (div_status.busy || div_status.done))
    else $error("waiting on an idle divider");
`endif

endmodule

/* bench/hall_period_speed_estimator_core_tb.sv */
// self-checking bench for the hall period speed estimator core
module hall_period_speed_estimator_core_tb import hpse_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RING_DEPTH    = 12;
  localparam int TIMER_RATE_HZ = 500000;
  localparam int SETTLE_CYCLES = 40;

  typedef struct packed {
    logic [SPEED_W-1:0] speed;
    logic               live;
  } reading_t;

  class speed_tracker;
    logic [AGE_W-1:0]    timeout;
    logic [PERIOD_W-1:0] ring [RING_DEPTH];
    logic [19:0]         sum;
    int unsigned         slot;
    int unsigned         fill;
    bit                  skip_edge;
    bit                  lost_latched;
    logic [AGE_W-1:0]    last_age;
    logic [SPEED_W-1:0]  speed;
    reading_t            speed_due[$];
    int                  errors;

    function new();
      timeout = TIMEOUT_RESET;
      errors  = 0;
      restart();
    endfunction

    function void restart();
      sum          = '0;
      slot         = 0;
      fill         = 0;
      skip_edge    = 1'b1;
      lost_latched = 1'b0;
      last_age     = AGE_RESET;
      speed        = '0;
    endfunction

    function void empty_ring();
      sum  = '0;
      slot = 0;
      fill = 0;
    endfunction

    function void ring_insert(logic [PERIOD_W-1:0] period);
      longint unsigned num;
      longint unsigned den;
      longint unsigned quo;
      if (fill < RING_DEPTH) fill++;
      else sum = sum - ring[slot];
      ring[slot] = period;
      sum = sum + period;
      slot = (slot + 1 >= RING_DEPTH) ? 0 : slot + 1;
      if (sum != 0) begin
        num = longint'(TIMER_RATE_HZ) * fill;
        den = longint'(sum) * 6;
        quo = num / den;
        speed = (quo > SPEED_MAX) ? SPEED_MAX : quo[SPEED_W-1:0];
      end
    endfunction

    function void note_tick(logic clr, logic [AGE_W-1:0] age, logic [PERIOD_W-1:0] period);
      reading_t r;
      bit       live;
      bit       hit;
      if (clr) begin
        restart();
        r.speed = '0;
        r.live  = 1'b0;
      end else begin
        live = (age <= timeout);
        hit  = live && (age < last_age);
        if (!live && !lost_latched) begin
          empty_ring();
          skip_edge    = 1'b1;
          lost_latched = 1'b1;
          speed        = '0;
        end
        if (hit) begin
          lost_latched = 1'b0;
          if (skip_edge) skip_edge = 1'b0;
          else if (period != 0) ring_insert(period);
        end
        last_age = age;
        if (!live) speed = '0;
        r.speed = speed;
        r.live  = live;
      end
      speed_due.push_back(r);
    endfunction

    function void check_reading(logic [SPEED_W-1:0] got_speed, logic got_live);
      reading_t w;
      if (speed_due.size() == 0) begin
        $display("%0t unexpected beat: speed_erps %0d signal_valid %0b",
                 $time, got_speed, got_live);
        errors++;
        return;
      end
      w = speed_due.pop_front();
      if (got_speed !== w.speed) begin
        $display("%0t speed_erps mismatch: expected %0d, actual %0d", $time, w.speed, got_speed);
        errors++;
      end
      if (got_live !== w.live) begin
        $display("%0t signal_valid mismatch: expected %0b, actual %0b", $time, w.live, got_live);
        errors++;
      end
    endfunction

    function int pending();
      return speed_due.size();
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic                in_clear;
  logic [AGE_W-1:0]    in_edge_age;
  logic [PERIOD_W-1:0] in_period_ticks;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [SPEED_W-1:0]  out_speed_erps;
  logic                out_signal_valid;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [DATA_W-1:0]   pwdata;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  speed_tracker tracker = new();
  bit           quiet = 1'b0;
  int unsigned  stall_left = 0;
  int unsigned  motor_age = 0;

  hall_period_speed_estimator_core #(
    .RING_DEPTH   (RING_DEPTH),
    .TIMER_RATE_HZ(TIMER_RATE_HZ)
  ) DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_clear        (in_clear),
    .in_edge_age     (in_edge_age),
    .in_period_ticks (in_period_ticks),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_speed_erps  (out_speed_erps),
    .out_signal_valid(out_signal_valid),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // accepted beats on both channels, input noted first
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) tracker.note_tick(in_clear, in_edge_age, in_period_ticks);
      if (out_valid && !out_stall) tracker.check_reading(out_speed_erps, out_signal_valid);
    end
  end

  // receiver backpressure in random bursts
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 6);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic send_tick(logic clr, logic [AGE_W-1:0] age, logic [PERIOD_W-1:0] period);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_clear        <= clr;
    in_edge_age     <= age;
    in_period_ticks <= period;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    // one edge first so the last accepted beat is already noted
    @(posedge clk);
    while (tracker.pending() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_timeout(logic [AGE_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_TIMEOUT, 2'b00};
    pwdata  <= DATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    tracker.timeout = value;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[AGE_W-1:0] !== value) begin
      $display("%0t timeout_ticks readback mismatch: expected %0d, actual %0d",
               $time, value, prdata[AGE_W-1:0]);
      tracker.errors++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [PERIOD_W-1:0] pick_period();
    case ($urandom_range(0, 9))
      0:       return '0;
      1, 2:    return PERIOD_W'($urandom_range(1, 40));
      3:       return '1;
      4, 5, 6: return PERIOD_W'($urandom_range(1, 3000));
      default: return PERIOD_W'($urandom_range(1, 65535));
    endcase
  endfunction

  // mostly a turning motor: age climbs, drops at each edge, stalls past the timeout
  task automatic run_motor(int count, int unsigned tmo);
    int unsigned step_max;
    int unsigned r;
    step_max = tmo / 6 + 1;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 2) begin
        send_tick(1'b1, AGE_W'($urandom), PERIOD_W'($urandom));
        motor_age = $urandom_range(0, 65535);
      end else if (r < 8) begin
        send_tick(1'b0, AGE_W'($urandom), PERIOD_W'($urandom));
      end else if (motor_age > 0 && $urandom_range(0, 3) == 0) begin
        motor_age = $urandom_range(0, motor_age - 1);
        send_tick(1'b0, AGE_W'(motor_age), pick_period());
      end else begin
        motor_age = motor_age + $urandom_range(1, step_max);
        if (motor_age > 65535) motor_age = 65535;
        send_tick(1'b0, AGE_W'(motor_age), pick_period());
      end
    end
  endtask

  initial begin
    rst_n           <= 1'b0;
    in_valid        <= 1'b0;
    in_clear        <= 1'b0;
    in_edge_age     <= '0;
    in_period_ticks <= '0;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_timeout(16'd800);

    // directed: clear, skipped first edge, edges with extreme periods, timeout handling
    send_tick(1'b1, 16'hFFFF, 16'hFFFF);
    send_tick(1'b0, 16'd100, 16'd50);
    send_tick(1'b0, 16'd200, 16'd9);
    send_tick(1'b0, 16'd10, 16'd1);
    send_tick(1'b0, 16'd0, 16'hFFFF);
    send_tick(1'b0, 16'd0, 16'd5);
    send_tick(1'b0, 16'd800, 16'd0);
    send_tick(1'b0, 16'd5, 16'd0);
    send_tick(1'b0, 16'd801, 16'd3);
    send_tick(1'b0, 16'hFFFF, 16'd3);
    send_tick(1'b0, 16'd3, 16'd7);
    // falling ages make every tick after the first an edge, enough to wrap the ring
    for (int i = 0; i < 14; i++)
      send_tick(1'b0, AGE_W'(700 - i), PERIOD_W'(i * 4000 + 1));
    send_tick(1'b1, 16'd12, 16'd34);
    wait_idle();

    write_timeout(16'hFFFF);
    run_motor(350, 65535);
    wait_idle();
    write_timeout(16'd0);
    run_motor(200, 0);
    wait_idle();
    write_timeout(AGE_W'($urandom_range(50, 2000)));
    run_motor(400, tracker.timeout);
    wait_idle();
    write_timeout(16'd800);
    run_motor(200, 800);
    // sender holds off until everything is out
    wait_idle();
    run_motor(200, 800);
    wait_idle();
    quiet = 1'b1;
    write_timeout(16'd1000);
    run_motor(400, 1000);
    wait_idle();

    if (tracker.errors == 0 && tracker.pending() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #10_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

/* files.f */
hw/rtl/hpse_pkg.sv
hw/rtl/hpse_divider.sv
hw/rtl/hall_period_speed_estimator_core.sv
bench/hall_period_speed_estimator_core_tb.sv
